// File: rtl/srsp_pkg.sv
`default_nettype none

package srsp_pkg;

  // Stack geometry: slot 0 is never used, so STACK_DEPTH-1 entries are live at most
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int ADDR_W      = 32;
  localparam int LEVEL_W     = 4;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STACK_DEPTH - 1);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_RESOLVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_CHK,
    ST_RES_RD,
    ST_RES_CHK,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;        // latch the input transaction
    logic push_we;    // write new top entry and post result
    logic rd_top;     // read the top entry
    logic pop_fin;    // compare top entry, pop on match, post result
    logic scan_init;  // start the resolve scan at the first slot
    logic rd_scan;    // read the entry under the scan pointer
    logic res_chk;    // fill host address of the scanned entry on match
    logic scan_inc;   // advance the scan pointer
    logic out_plain;  // post a miss with the current level
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       host_zero;
    logic       top_zero;
    logic       scan_last;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/srsp_if.sv
`default_nettype none

// Input channel: one stack operation per transaction
interface srsp_in_if import srsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ADDR_W-1:0] guest_addr;
  logic [ADDR_W-1:0] host_addr;

  modport source (output valid, output opcode, output guest_addr, output host_addr,
                  input ready);
  modport sink   (input valid, input opcode, input guest_addr, input host_addr,
                  output ready);
endinterface

// Result channel: one prediction per transaction
interface srsp_out_if import srsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [ADDR_W-1:0]  target;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output hit, output target, output level, input ready);
  modport sink   (input valid, input hit, input target, input level, output ready);
endinterface

`default_nettype wire

// File: rtl/srsp_ctrl.sv
`default_nettype none

module srsp_ctrl import srsp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.opcode)
          OP_PUSH: begin
            if (stat.out_free) begin
              cmd.push_we = 1'b1;
              state_nxt   = ST_IDLE;
            end
          end
          OP_POP: begin
            cmd.rd_top = 1'b1;
            state_nxt  = ST_POP_CHK;
          end
          OP_RESOLVE: begin
            if (stat.host_zero || stat.top_zero) begin
              if (stat.out_free) begin
                cmd.out_plain = 1'b1;
                state_nxt     = ST_IDLE;
              end
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = ST_RES_RD;
            end
          end
          default: begin
            // undefined opcode: no effect, plain miss
            if (stat.out_free) begin
              cmd.out_plain = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
        endcase
      end
      ST_POP_CHK: begin
        if (stat.out_free) begin
          cmd.pop_fin = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_RES_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = ST_RES_CHK;
      end
      ST_RES_CHK: begin
        cmd.res_chk = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = ST_RES_RD;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.out_plain = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/srsp_dpath.sv
`default_nettype none

module srsp_dpath import srsp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [ADDR_W-1:0]  in_guest_addr,
  input  wire logic [ADDR_W-1:0]  in_host_addr,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_hit,
  output logic [ADDR_W-1:0]       out_target,
  output logic [LEVEL_W-1:0]      out_level
);

  // Stack storage, one read and one write port per array
  logic [ADDR_W-1:0] guest_mem [STACK_DEPTH];
  logic [ADDR_W-1:0] host_mem  [STACK_DEPTH];

  logic [1:0]         op_r;
  logic [ADDR_W-1:0]  guest_r;
  logic [ADDR_W-1:0]  host_r;
  logic [IDX_W-1:0]   top_r, top_nxt;
  logic [IDX_W-1:0]   scan_r;
  logic [ADDR_W-1:0]  guest_q_r;
  logic [ADDR_W-1:0]  host_q_r;

  logic               out_valid_r;
  logic               hit_r;
  logic [ADDR_W-1:0]  target_r;
  logic [LEVEL_W-1:0] level_r;

  logic [IDX_W-1:0]   push_idx;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               top_match;
  logic               res_match;
  logic               load_out;
  logic               hit_nxt;
  logic [ADDR_W-1:0]  target_nxt;

  // Push slot wraps back to the first slot when the stack is full
  assign push_idx = (top_r == LAST_IDX) ? FIRST_IDX : top_r + FIRST_IDX;

  assign rd_en   = cmd.rd_top || cmd.rd_scan;
  assign rd_addr = cmd.rd_scan ? scan_r : top_r;

  assign top_match = (top_r != '0) && (guest_q_r == guest_r);
  assign res_match = (guest_q_r == guest_r) && (host_q_r == '0);

  // Captured transaction
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r    <= in_opcode;
      guest_r <= in_guest_addr;
      host_r  <= in_host_addr;
    end
  end

  // Memory write ports
  always_ff @(posedge clk) begin
    if (cmd.push_we) begin
      guest_mem[push_idx] <= guest_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_we) begin
      host_mem[push_idx] <= host_r;
    end else if (cmd.res_chk && res_match) begin
      host_mem[scan_r] <= host_r;
    end
  end

  // Registered memory read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      guest_q_r <= guest_mem[rd_addr];
      host_q_r  <= host_mem[rd_addr];
    end
  end

  // Stack pointer
  always_comb begin
    top_nxt = top_r;
    if (cmd.push_we) begin
      top_nxt = push_idx;
    end else if (cmd.pop_fin && top_match) begin
      top_nxt = top_r - FIRST_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else begin
      top_r <= top_nxt;
    end
  end

  // Resolve scan pointer
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_r <= FIRST_IDX;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + FIRST_IDX;
    end
  end

  // Result values
  always_comb begin
    hit_nxt    = 1'b0;
    target_nxt = '0;
    if (cmd.pop_fin && top_match && (host_q_r != '0)) begin
      hit_nxt    = 1'b1;
      target_nxt = host_q_r;
    end
  end

  // Output register
  assign load_out = cmd.push_we || cmd.pop_fin || cmd.out_plain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit_r    <= hit_nxt;
      target_r <= target_nxt;
      level_r  <= LEVEL_W'(top_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = hit_r;
  assign out_target = target_r;
  assign out_level  = level_r;

  // Status
  assign stat.opcode    = op_r;
  assign stat.host_zero = (host_r == '0);
  assign stat.top_zero  = (top_r == '0);
  assign stat.scan_last = (scan_r == top_r);
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// File: rtl/shadow_return_stack_predictor_top.sv
// Push: writes the entry and posts the result once the output is free, then idles.
// Pop: one registered read of the top entry before the compare.
// Resolve: reads, then checks, each entry from the first slot to the top through the
// single memory read port; a zero host address or empty stack skips the scan.
// Reset (rst_n low, synchronous) empties the stack and the output register;
// the entry memories are not cleared.
`default_nettype none

module shadow_return_stack_predictor_top import srsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  srsp_in_if.sink    in_ch,
  srsp_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  srsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srsp_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (in_ch.opcode),
    .in_guest_addr (in_ch.guest_addr),
    .in_host_addr  (in_ch.host_addr),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_hit       (out_ch.hit),
    .out_target    (out_ch.target),
    .out_level     (out_ch.level)
  );

endmodule

`default_nettype wire

// File: rtl/srsp_checker.sv
`default_nettype none

module srsp_checker import srsp_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_hit,
  input wire logic [ADDR_W-1:0]  out_target,
  input wire logic [LEVEL_W-1:0] out_level
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_target)
                                && $stable(out_level))
    else $error("result changed while stalled");

  // A miss always predicts zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_target == '0)
    else $error("miss with nonzero target");

  // A hit always carries a known host address
  a_hit_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_target != '0)
    else $error("hit with zero target");

  // One operation at a time: no acceptance in the cycle after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

endmodule

bind shadow_return_stack_predictor_top srsp_checker u_srsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_hit    (out_ch.hit),
  .out_target (out_ch.target),
  .out_level  (out_ch.level)
);

`default_nettype wire
